/* src/drchd_pkg.sv */
// ----------------------------------------------------------------------------
// drchd_pkg
// Types and constants shared by the dial region color hit detector:
// register layout, reset values, region geometry and the queue entry.
// ----------------------------------------------------------------------------
`default_nettype none

package drchd_pkg;

   localparam int REGION_COUNT = 8;
   localparam int REGION_SIDE  = 8;
   localparam int REGION_IDX_W = $clog2(REGION_COUNT);

   localparam int COORD_W = 9;
   localparam int COLOR_W = 8;
   localparam int COUNT_W = 7;
   localparam int STEP_W  = 8;
   localparam int GB_W    = 9;
   // signed corner position: covers -255 .. 766
   localparam int CORNER_W = COORD_W + 2;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 9;

   localparam logic [CSR_INDEX_W-1:0] CSR_RED_MIN         = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GREEN_BLUE_MAX  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_HIT_MIN         = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_CENTER_X        = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_CENTER_Y        = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_RADIUS          = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_DIAGONAL_OFFSET = 3'd6;

   localparam logic [COLOR_W-1:0] RED_MIN_RST         = 8'd50;
   localparam logic [GB_W-1:0]    GREEN_BLUE_MAX_RST  = 9'd70;
   localparam logic [COUNT_W-1:0] HIT_MIN_RST         = 7'd13;
   localparam logic [COORD_W-1:0] CENTER_X_RST        = 9'd105;
   localparam logic [COORD_W-1:0] CENTER_Y_RST        = 9'd32;
   localparam logic [STEP_W-1:0]  RADIUS_RST          = 8'd18;
   localparam logic [STEP_W-1:0]  DIAGONAL_OFFSET_RST = 8'd13;

   typedef enum logic [1:0] {
      DIR_NEG,
      DIR_ZERO,
      DIR_POS
   } offset_dir_type;

   // corner placement per region, index 0 first
   localparam offset_dir_type CORNER_DX [REGION_COUNT] = '{
      DIR_NEG, DIR_NEG, DIR_NEG, DIR_ZERO, DIR_POS, DIR_POS, DIR_POS, DIR_ZERO
   };
   localparam offset_dir_type CORNER_DY [REGION_COUNT] = '{
      DIR_POS, DIR_ZERO, DIR_NEG, DIR_NEG, DIR_NEG, DIR_ZERO, DIR_POS, DIR_POS
   };
   localparam logic [REGION_COUNT-1:0] CORNER_DIAG = 8'b0101_0101;

   typedef struct packed {
      logic [COLOR_W-1:0] red_min;
      logic [GB_W-1:0]    green_blue_max;
      logic [COUNT_W-1:0] hit_min;
      logic [COORD_W-1:0] center_x;
      logic [COORD_W-1:0] center_y;
      logic [STEP_W-1:0]  radius;
      logic [STEP_W-1:0]  diagonal_offset;
   } cfg_type;

   typedef struct packed {
      logic [REGION_COUNT-1:0] hits;
      logic                    frame_end;
   } pix_item_type;

   function automatic logic signed [CORNER_W-1:0] place_corner(
      input logic [COORD_W-1:0] base,
      input logic [STEP_W-1:0]  step,
      input offset_dir_type     dir
   );
      logic signed [CORNER_W-1:0] b;
      logic signed [CORNER_W-1:0] s;
      b = $signed({2'b00, base});
      s = $signed({3'b000, step});
      case (dir)
         DIR_NEG: place_corner = b - s;
         DIR_POS: place_corner = b + s;
         default: place_corner = b;
      endcase
   endfunction

   // pixel coordinate lies in corner .. corner+REGION_SIDE-1, corner on grid
   function automatic logic in_span(
      input logic signed [CORNER_W-1:0] corner,
      input logic [COORD_W-1:0]         p
   );
      logic signed [CORNER_W-1:0] diff;
      logic                       on_grid;
      on_grid = (corner[CORNER_W-1] == 1'b0) && (corner[CORNER_W-2] == 1'b0);
      diff = $signed({2'b00, p}) - corner;
      in_span = on_grid && !diff[CORNER_W-1]
                && (diff[CORNER_W-2:0] < (CORNER_W-1)'(REGION_SIDE));
   endfunction

endpackage

`default_nettype wire

/* src/dial_region_color_hit_detector.sv */
// ----------------------------------------------------------------------------
// dial_region_color_hit_detector
// Counts red pixels in eight boxes around a dial and reports the first box
// that reaches the hit threshold at each frame end.
// ----------------------------------------------------------------------------
//
//  port group   direction  handshake            carries
//  req_*        in         req_valid/req_stall  pix_x, pix_y, red/green/blue, frame_end
//  rsp_*        out        rsp_valid/rsp_stall  hit_found, hit_region (frame end only)
//  csr_*        in         csr_wr_en            register index and write data
//
//  Takes one pixel per clock while the queue is not full; the classify logic feeds a QUEUE_DEPTH entry queue.
//  A frame-end pixel's result is registered: it passes through the queue, then the result register.
//  Only frame-end pixels wait on rsp_stall; the queue absorbs that wait.
//  Reset loads the register defaults and zeroes all counts.
//  req_stall rises only when the queue is full.
// ----------------------------------------------------------------------------
`default_nettype none

module dial_region_color_hit_detector #(
   parameter int QUEUE_DEPTH = 4   // 2 or more
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,

   input  wire logic                                    req_valid,
   output logic                                         req_stall,
   input  wire logic [drchd_pkg::COORD_W-1:0]           req_pix_x,
   input  wire logic [drchd_pkg::COORD_W-1:0]           req_pix_y,
   input  wire logic [drchd_pkg::COLOR_W-1:0]           req_red_val,
   input  wire logic [drchd_pkg::COLOR_W-1:0]           req_green_val,
   input  wire logic [drchd_pkg::COLOR_W-1:0]           req_blue_val,
   input  wire logic                                    req_frame_end,

   output logic                                         rsp_valid,
   input  wire logic                                    rsp_stall,
   output logic                                         rsp_hit_found,
   output logic [drchd_pkg::REGION_IDX_W-1:0]           rsp_hit_region,

   input  wire logic                                    csr_wr_en,
   input  wire logic [drchd_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  wire logic [drchd_pkg::CSR_DATA_W-1:0]        csr_wdata
);

   drchd_pkg::cfg_type       cfg_ff, cfg_in;
   drchd_pkg::pix_item_type  front_item;
   drchd_pkg::pix_item_type  head_item;
   logic                     q_full;
   logic                     q_empty;
   logic                     q_push;
   logic                     q_pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            drchd_pkg::CSR_RED_MIN:         cfg_in.red_min         = csr_wdata[7:0];
            drchd_pkg::CSR_GREEN_BLUE_MAX:  cfg_in.green_blue_max  = csr_wdata;
            drchd_pkg::CSR_HIT_MIN:         cfg_in.hit_min         = csr_wdata[6:0];
            drchd_pkg::CSR_CENTER_X:        cfg_in.center_x        = csr_wdata;
            drchd_pkg::CSR_CENTER_Y:        cfg_in.center_y        = csr_wdata;
            drchd_pkg::CSR_RADIUS:          cfg_in.radius          = csr_wdata[7:0];
            drchd_pkg::CSR_DIAGONAL_OFFSET: cfg_in.diagonal_offset = csr_wdata[7:0];
            default:                        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.red_min         <= drchd_pkg::RED_MIN_RST;
         cfg_ff.green_blue_max  <= drchd_pkg::GREEN_BLUE_MAX_RST;
         cfg_ff.hit_min         <= drchd_pkg::HIT_MIN_RST;
         cfg_ff.center_x        <= drchd_pkg::CENTER_X_RST;
         cfg_ff.center_y        <= drchd_pkg::CENTER_Y_RST;
         cfg_ff.radius          <= drchd_pkg::RADIUS_RST;
         cfg_ff.diagonal_offset <= drchd_pkg::DIAGONAL_OFFSET_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;

   drchd_front u_front (
      .cfg       (cfg_ff),
      .pix_x     (req_pix_x),
      .pix_y     (req_pix_y),
      .red_val   (req_red_val),
      .green_val (req_green_val),
      .blue_val  (req_blue_val),
      .frame_end (req_frame_end),
      .item      (front_item)
   );

   drchd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (front_item),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (head_item),
      .empty     (q_empty)
   );

   drchd_back u_back (
      .clock          (clock),
      .reset          (reset),
      .hit_min        (cfg_ff.hit_min),
      .item_avail     (!q_empty),
      .item           (head_item),
      .item_take      (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_hit_found  (rsp_hit_found),
      .rsp_hit_region (rsp_hit_region)
   );

endmodule

`default_nettype wire

/* src/drchd_front.sv */
// ----------------------------------------------------------------------------
// drchd_front
// Classifies one pixel: red test and the eight region box compares.
// ----------------------------------------------------------------------------
`default_nettype none

module drchd_front (
   input  wire drchd_pkg::cfg_type              cfg,
   input  wire logic [drchd_pkg::COORD_W-1:0]   pix_x,
   input  wire logic [drchd_pkg::COORD_W-1:0]   pix_y,
   input  wire logic [drchd_pkg::COLOR_W-1:0]   red_val,
   input  wire logic [drchd_pkg::COLOR_W-1:0]   green_val,
   input  wire logic [drchd_pkg::COLOR_W-1:0]   blue_val,
   input  wire logic                            frame_end,
   output drchd_pkg::pix_item_type              item
);

   logic                                is_red;
   logic [drchd_pkg::GB_W-1:0]          gb_sum;
   logic [drchd_pkg::REGION_COUNT-1:0]  in_box;

   assign gb_sum = {1'b0, green_val} + {1'b0, blue_val};
   assign is_red = (red_val > cfg.red_min) && (gb_sum < cfg.green_blue_max);

   always_comb begin
      logic [drchd_pkg::STEP_W-1:0]            step;
      logic signed [drchd_pkg::CORNER_W-1:0]   cx;
      logic signed [drchd_pkg::CORNER_W-1:0]   cy;
      for (int i = 0; i < drchd_pkg::REGION_COUNT; i++) begin
         step = drchd_pkg::CORNER_DIAG[i] ? cfg.diagonal_offset : cfg.radius;
         cx = drchd_pkg::place_corner(cfg.center_x, step, drchd_pkg::CORNER_DX[i]);
         cy = drchd_pkg::place_corner(cfg.center_y, step, drchd_pkg::CORNER_DY[i]);
         in_box[i] = drchd_pkg::in_span(cx, pix_x) && drchd_pkg::in_span(cy, pix_y);
      end
   end

   always_comb begin
      item.hits      = is_red ? in_box : '0;
      item.frame_end = frame_end;
   end

endmodule

`default_nettype wire

/* src/drchd_queue.sv */
// ----------------------------------------------------------------------------
// drchd_queue
// Small first-in first-out queue of classified pixels between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module drchd_queue #(
   parameter int DEPTH = 4
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      push,
   input  wire drchd_pkg::pix_item_type   push_data,
   output logic                           full,
   input  wire logic                      pop,
   output drchd_pkg::pix_item_type        pop_data,
   output logic                           empty
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   drchd_pkg::pix_item_type slot_ff [DEPTH];

   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full     = (count_ff == CNT_FULL);
   assign empty    = (count_ff == '0);
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (!full || pop))
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("queue read while empty");

   a_count_tracks: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue fill count out of step");

endmodule

`default_nettype wire

/* src/drchd_back.sv */
// ----------------------------------------------------------------------------
// drchd_back
// Region red counters and end-of-frame hit report with a result register.
// ----------------------------------------------------------------------------
`default_nettype none

module drchd_back (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic [drchd_pkg::COUNT_W-1:0]       hit_min,
   input  wire logic                                item_avail,
   input  wire drchd_pkg::pix_item_type             item,
   output logic                                     item_take,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic                                     rsp_hit_found,
   output logic [drchd_pkg::REGION_IDX_W-1:0]       rsp_hit_region
);

   logic [drchd_pkg::COUNT_W-1:0] cnt_ff  [drchd_pkg::REGION_COUNT];
   logic [drchd_pkg::COUNT_W-1:0] cnt_new [drchd_pkg::REGION_COUNT];

   logic                                  rsp_valid_ff, rsp_valid_in;
   logic                                  found_ff;
   logic [drchd_pkg::REGION_IDX_W-1:0]    region_ff;
   logic                                  found;
   logic [drchd_pkg::REGION_IDX_W-1:0]    which;
   logic                                  close_frame;

   // a frame end may only leave the queue when the result slot frees up
   assign item_take   = item_avail && (!item.frame_end || !rsp_valid_ff || !rsp_stall);
   assign close_frame = item_take && item.frame_end;

   always_comb begin
      for (int i = 0; i < drchd_pkg::REGION_COUNT; i++) begin
         cnt_new[i] = cnt_ff[i]
                      + drchd_pkg::COUNT_W'(item.hits[i] && (cnt_ff[i] != drchd_pkg::COUNT_MAX));
      end
   end

   // lowest region index wins
   always_comb begin
      found = 1'b0;
      which = '0;
      for (int i = drchd_pkg::REGION_COUNT - 1; i >= 0; i--) begin
         if (cnt_new[i] >= hit_min) begin
            found = 1'b1;
            which = drchd_pkg::REGION_IDX_W'(i);
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (close_frame) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < drchd_pkg::REGION_COUNT; i++) begin
            cnt_ff[i] <= '0;
         end
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (close_frame) begin
            for (int i = 0; i < drchd_pkg::REGION_COUNT; i++) begin
               cnt_ff[i] <= '0;
            end
         end else if (item_take) begin
            for (int i = 0; i < drchd_pkg::REGION_COUNT; i++) begin
               cnt_ff[i] <= cnt_new[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (close_frame) begin
         found_ff  <= found;
         region_ff <= which;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hit_found  = found_ff;
   assign rsp_hit_region = region_ff;

   a_rsp_from_frame_end: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(close_frame))
      else $error("result raised without a frame end");

   a_counts_cleared: assert property (@(posedge clock) disable iff (reset)
      close_frame |=> (cnt_ff[0] == '0) && (cnt_ff[drchd_pkg::REGION_COUNT-1] == '0))
      else $error("region counts not cleared after frame end");

   a_no_result_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !close_frame)
      else $error("pending result overwritten");

endmodule

`default_nettype wire

/* tb/dial_region_color_hit_detector_tb.sv */
// ----------------------------------------------------------------------------
// dial_region_color_hit_detector_tb
// Streams pixel beats through the dial region hit detector under changing
// register settings and handshake pressure. A local copy of the region
// counts predicts each frame-end verdict, and every result beat is checked
// field by field against the oldest pending verdict.
// ----------------------------------------------------------------------------
module dial_region_color_hit_detector_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [drchd_pkg::CSR_INDEX_W-1:0] CSR_UNUSED_INDEX = 3'd7;
   localparam int COORD_TOP    = (1 << drchd_pkg::COORD_W) - 1;
   localparam int TALLY_TOP    = (1 << drchd_pkg::COUNT_W) - 1;
   localparam int DRAIN_CYCLES = 6;

   typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_STALL, IDLE_BOTH} idle_mode_type;
   typedef enum int {SHADE_RED, SHADE_EDGE, SHADE_ANY} shade_kind_type;

   typedef struct packed {
      logic [drchd_pkg::COORD_W-1:0] x;
      logic [drchd_pkg::COORD_W-1:0] y;
      logic [drchd_pkg::COLOR_W-1:0] red;
      logic [drchd_pkg::COLOR_W-1:0] green;
      logic [drchd_pkg::COLOR_W-1:0] blue;
      logic                          last;
   } pixel_beat_type;

   typedef struct packed {
      logic                               found;
      logic [drchd_pkg::REGION_IDX_W-1:0] region;
   } hit_verdict_type;

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               req_valid = 1'b0;
   logic                               req_stall;
   logic [drchd_pkg::COORD_W-1:0]      req_pix_x = '0;
   logic [drchd_pkg::COORD_W-1:0]      req_pix_y = '0;
   logic [drchd_pkg::COLOR_W-1:0]      req_red_val = '0;
   logic [drchd_pkg::COLOR_W-1:0]      req_green_val = '0;
   logic [drchd_pkg::COLOR_W-1:0]      req_blue_val = '0;
   logic                               req_frame_end = 1'b0;
   logic                               rsp_valid;
   logic                               rsp_stall = 1'b0;
   logic                               rsp_hit_found;
   logic [drchd_pkg::REGION_IDX_W-1:0] rsp_hit_region;
   logic                               csr_wr_en = 1'b0;
   logic [drchd_pkg::CSR_INDEX_W-1:0]  csr_index = '0;
   logic [drchd_pkg::CSR_DATA_W-1:0]   csr_wdata = '0;

   pixel_beat_type     pixel_q [$];
   hit_verdict_type    hit_verdict_q [$];
   pixel_beat_type     next_beat;
   hit_verdict_type    want;
   drchd_pkg::cfg_type shadow_cfg;
   int           region_tally [drchd_pkg::REGION_COUNT];
   int           x_sign [drchd_pkg::REGION_COUNT] = '{-1, -1, -1, 0, 1, 1, 1, 0};
   int           y_sign [drchd_pkg::REGION_COUNT] = '{1, 0, -1, -1, -1, 0, 1, 1};
   bit           on_diagonal [drchd_pkg::REGION_COUNT] = '{1, 0, 1, 0, 1, 0, 1, 0};
   int           send_idle_pct = 0;
   int           stall_pct = 0;
   int           beats_pushed = 0;
   int           beats_taken = 0;
   int           error_count = 0;

   dial_region_color_hit_detector u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_pix_x      (req_pix_x),
      .req_pix_y      (req_pix_y),
      .req_red_val    (req_red_val),
      .req_green_val  (req_green_val),
      .req_blue_val   (req_blue_val),
      .req_frame_end  (req_frame_end),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_hit_found  (rsp_hit_found),
      .rsp_hit_region (rsp_hit_region),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("dial_region_color_hit_detector regression: fail");
      $finish;
   end

   task automatic report_mismatch(string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      error_count++;
   endtask

   function automatic void region_corner(input int region, output int cx, output int cy);
      int step;
      step = on_diagonal[region] ? int'(shadow_cfg.diagonal_offset) : int'(shadow_cfg.radius);
      cx = int'(shadow_cfg.center_x) + x_sign[region] * step;
      cy = int'(shadow_cfg.center_y) + y_sign[region] * step;
   endfunction

   function automatic bit covers(int corner, int p);
      return corner >= 0 && corner <= COORD_TOP && p >= corner
             && p < corner + drchd_pkg::REGION_SIDE;
   endfunction

   // advance the region counts by one accepted beat; close the frame on its last pixel
   function automatic void tally_pixel(pixel_beat_type p);
      int              cx, cy;
      bit              is_red;
      hit_verdict_type v;
      is_red = (p.red > shadow_cfg.red_min)
               && (int'(p.green) + int'(p.blue) < int'(shadow_cfg.green_blue_max));
      if (is_red) begin
         for (int i = 0; i < drchd_pkg::REGION_COUNT; i++) begin
            region_corner(i, cx, cy);
            if (covers(cx, int'(p.x)) && covers(cy, int'(p.y)) && region_tally[i] < TALLY_TOP)
               region_tally[i]++;
         end
      end
      if (p.last) begin
         v = '0;
         for (int i = drchd_pkg::REGION_COUNT - 1; i >= 0; i--) begin
            if (region_tally[i] >= int'(shadow_cfg.hit_min)) begin
               v.found = 1'b1;
               v.region = drchd_pkg::REGION_IDX_W'(i);
            end
         end
         hit_verdict_q.push_back(v);
         foreach (region_tally[i]) region_tally[i] = 0;
      end
   endfunction

   function automatic pixel_beat_type shade(int x, int y, shade_kind_type kind, bit last);
      pixel_beat_type p;
      int             rmin, gbmax, top, sum;
      rmin = int'(shadow_cfg.red_min);
      gbmax = int'(shadow_cfg.green_blue_max);
      p.x = drchd_pkg::COORD_W'(x);
      p.y = drchd_pkg::COORD_W'(y);
      p.last = last;
      p.red = 8'($urandom);
      p.green = 8'($urandom);
      p.blue = 8'($urandom);
      if (kind == SHADE_RED && rmin < 255 && gbmax > 0) begin
         p.red = 8'($urandom_range(255, rmin + 1));
         top = (gbmax - 1 > 255) ? 255 : gbmax - 1;
         p.green = 8'($urandom_range(top, 0));
         top = gbmax - 1 - int'(p.green);
         p.blue = 8'($urandom_range(top > 255 ? 255 : top, 0));
      end else if (kind == SHADE_EDGE) begin
         // sit right on the red and green+blue thresholds
         p.red = 8'(rmin + int'($urandom_range(1, 0)));
         sum = gbmax - int'($urandom_range(1, 0));
         if (sum < 0) sum = 0;
         if (sum > 510) sum = 510;
         p.green = 8'($urandom_range(sum > 255 ? 255 : sum, sum > 255 ? sum - 255 : 0));
         p.blue = 8'(sum - int'(p.green));
      end
      return p;
   endfunction

   // pick a pixel in a region's box; spill lets it land one step outside
   function automatic pixel_beat_type aimed_beat(int region, shade_kind_type kind, bit spill,
                                                 bit last);
      int cx, cy, x, y;
      region_corner(region, cx, cy);
      x = cx + (spill ? int'($urandom_range(9, 0)) - 1 : int'($urandom_range(7, 0)));
      y = cy + (spill ? int'($urandom_range(9, 0)) - 1 : int'($urandom_range(7, 0)));
      if (x < 0 || x > COORD_TOP) x = int'($urandom_range(COORD_TOP, 0));
      if (y < 0 || y > COORD_TOP) y = int'($urandom_range(COORD_TOP, 0));
      return shade(x, y, kind, last);
   endfunction

   task automatic push_beat(pixel_beat_type p);
      pixel_q.push_back(p);
      beats_pushed++;
   endtask

   task automatic queue_frame(int len);
      int focus, pick;
      focus = $urandom_range(drchd_pkg::REGION_COUNT - 1, 0);
      for (int k = 0; k < len; k++) begin
         pick = $urandom_range(99, 0);
         if (pick < 55)
            push_beat(aimed_beat(focus, SHADE_RED, 1'b1, k == len - 1));
         else if (pick < 70)
            push_beat(aimed_beat($urandom_range(drchd_pkg::REGION_COUNT - 1, 0), SHADE_RED,
                                 1'b1, k == len - 1));
         else if (pick < 80)
            push_beat(aimed_beat(focus, SHADE_EDGE, 1'b1, k == len - 1));
         else
            push_beat(shade($urandom_range(COORD_TOP, 0), $urandom_range(COORD_TOP, 0),
                            SHADE_ANY, k == len - 1));
      end
   endtask

   task automatic write_reg(logic [drchd_pkg::CSR_INDEX_W-1:0] index,
                            logic [drchd_pkg::CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      case (index)
         drchd_pkg::CSR_RED_MIN:
            shadow_cfg.red_min = data[drchd_pkg::COLOR_W-1:0];
         drchd_pkg::CSR_GREEN_BLUE_MAX:
            shadow_cfg.green_blue_max = data[drchd_pkg::GB_W-1:0];
         drchd_pkg::CSR_HIT_MIN:
            shadow_cfg.hit_min = data[drchd_pkg::COUNT_W-1:0];
         drchd_pkg::CSR_CENTER_X:
            shadow_cfg.center_x = data[drchd_pkg::COORD_W-1:0];
         drchd_pkg::CSR_CENTER_Y:
            shadow_cfg.center_y = data[drchd_pkg::COORD_W-1:0];
         drchd_pkg::CSR_RADIUS:
            shadow_cfg.radius = data[drchd_pkg::STEP_W-1:0];
         drchd_pkg::CSR_DIAGONAL_OFFSET:
            shadow_cfg.diagonal_offset = data[drchd_pkg::STEP_W-1:0];
         default: ;
      endcase
   endtask

   // junk in the unused upper data bits must be dropped by the block
   task automatic load_config(int rm, int gbm, int hm, int cx, int cy, int rad, int diag);
      write_reg(CSR_UNUSED_INDEX, 9'($urandom));
      write_reg(drchd_pkg::CSR_RED_MIN, {1'($urandom), 8'(rm)});
      write_reg(drchd_pkg::CSR_GREEN_BLUE_MAX, 9'(gbm));
      write_reg(drchd_pkg::CSR_HIT_MIN, {2'($urandom), 7'(hm)});
      write_reg(drchd_pkg::CSR_CENTER_X, 9'(cx));
      write_reg(drchd_pkg::CSR_CENTER_Y, 9'(cy));
      write_reg(drchd_pkg::CSR_RADIUS, {1'($urandom), 8'(rad)});
      write_reg(drchd_pkg::CSR_DIAGONAL_OFFSET, {1'($urandom), 8'(diag)});
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic int pick_value(int lo, int hi, int ext_lo, int ext_hi);
      if ($urandom_range(3, 0) == 0)
         return $urandom_range(1, 0) ? ext_hi : ext_lo;
      return $urandom_range(hi, lo);
   endfunction

   task automatic set_idling(idle_mode_type mode);
      case (mode)
         IDLE_NONE:  begin send_idle_pct = 0;  stall_pct = 0;  end
         IDLE_SEND:  begin send_idle_pct = 63; stall_pct = 0;  end
         IDLE_STALL: begin send_idle_pct = 0;  stall_pct = 63; end
         default:    begin send_idle_pct = 36; stall_pct = 36; end
      endcase
   endtask

   // hold until every beat is taken and every verdict has come back, then drain
   task automatic settle();
      while (beats_taken != beats_pushed || hit_verdict_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // sender: offer a new beat only once the current one is gone
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (pixel_q.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
            next_beat = pixel_q.pop_front();
            req_valid <= 1'b1;
            req_pix_x <= next_beat.x;
            req_pix_y <= next_beat.y;
            req_red_val <= next_beat.red;
            req_green_val <= next_beat.green;
            req_blue_val <= next_beat.blue;
            req_frame_end <= next_beat.last;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99, 0) < stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         tally_pixel({req_pix_x, req_pix_y, req_red_val, req_green_val, req_blue_val,
                      req_frame_end});
         beats_taken++;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (hit_verdict_q.size() == 0) begin
            report_mismatch("result beat with no verdict pending");
         end else begin
            want = hit_verdict_q.pop_front();
            if (rsp_hit_found !== want.found)
               report_mismatch($sformatf("hit_found %b, expected %b", rsp_hit_found,
                                         want.found));
            if (rsp_hit_region !== want.region)
               report_mismatch($sformatf("hit_region %0d, expected %0d", rsp_hit_region,
                                         want.region));
         end
      end
   end

   initial begin
      int pushed;
      int len;
      shadow_cfg.red_min = drchd_pkg::RED_MIN_RST;
      shadow_cfg.green_blue_max = drchd_pkg::GREEN_BLUE_MAX_RST;
      shadow_cfg.hit_min = drchd_pkg::HIT_MIN_RST;
      shadow_cfg.center_x = drchd_pkg::CENTER_X_RST;
      shadow_cfg.center_y = drchd_pkg::CENTER_Y_RST;
      shadow_cfg.radius = drchd_pkg::RADIUS_RST;
      shadow_cfg.diagonal_offset = drchd_pkg::DIAGONAL_OFFSET_RST;
      foreach (region_tally[i]) region_tally[i] = 0;
      set_idling(IDLE_NONE);
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // register defaults: field extremes, a lone frame end, thresholds, a full hit
      push_beat('{9'd0, 9'd0, 8'd255, 8'd0, 8'd0, 1'b0});
      push_beat('{9'd511, 9'd511, 8'd255, 8'd255, 8'd255, 1'b0});
      push_beat('{9'd511, 9'd0, 8'd0, 8'd255, 8'd0, 1'b0});
      push_beat('{9'd0, 9'd511, 8'd0, 8'd0, 8'd255, 1'b0});
      push_beat(aimed_beat(5, SHADE_ANY, 1'b0, 1'b1));
      push_beat(aimed_beat(5, SHADE_EDGE, 1'b0, 1'b0));
      push_beat(aimed_beat(5, SHADE_EDGE, 1'b0, 1'b0));
      repeat (13) push_beat(aimed_beat(5, SHADE_RED, 1'b0, 1'b0));
      push_beat(aimed_beat(2, SHADE_ANY, 1'b1, 1'b1));
      settle();

      // all corners on the centre: one pixel lands in every region; zero threshold
      load_config(0, 511, 0, 200, 300, 0, 0);
      push_beat('{9'd203, 9'd304, 8'd200, 8'd10, 8'd10, 1'b0});
      push_beat('{9'd0, 9'd0, 8'd0, 8'd0, 8'd0, 1'b1});
      settle();
      load_config(0, 511, 2, 200, 300, 0, 0);
      push_beat('{9'd200, 9'd300, 8'd1, 8'd0, 8'd0, 1'b0});
      push_beat('{9'd207, 9'd307, 8'd9, 8'd255, 8'd255, 1'b1});
      settle();

      // corners pushed off the low and high edges of the grid
      load_config(50, 70, 1, 3, 508, 5, 5);
      push_beat('{9'd0, 9'd508, 8'd200, 8'd0, 8'd0, 1'b0});
      push_beat('{9'd1, 9'd511, 8'd200, 8'd0, 8'd0, 1'b0});
      push_beat('{9'd511, 9'd0, 8'd0, 8'd0, 8'd0, 1'b1});
      queue_frame(12);
      settle();
      load_config(50, 70, 1, 508, 3, 5, 5);
      push_beat('{9'd511, 9'd3, 8'd200, 8'd0, 8'd0, 1'b0});
      push_beat('{9'd509, 9'd0, 8'd200, 8'd0, 8'd0, 1'b0});
      push_beat('{9'd0, 9'd511, 8'd0, 8'd0, 8'd0, 1'b1});
      queue_frame(12);
      settle();

      // one count stops just short of the top threshold, another saturates
      load_config(50, 70, 127, 105, 32, 18, 13);
      repeat (126) push_beat(aimed_beat(1, SHADE_RED, 1'b0, 1'b0));
      repeat (135) push_beat(aimed_beat(3, SHADE_RED, 1'b0, 1'b0));
      push_beat('{9'd0, 9'd511, 8'd0, 8'd0, 8'd0, 1'b1});
      settle();

      for (int phase = 0; phase < 8; phase++) begin
         load_config(pick_value(0, 200, 0, 255), pick_value(20, 510, 0, 511),
                     pick_value(0, 8, 0, 127), pick_value(0, 511, 0, 511),
                     pick_value(0, 511, 0, 511), pick_value(0, 40, 0, 255),
                     pick_value(0, 40, 0, 255));
         set_idling(idle_mode_type'(phase % 4));
         pushed = 0;
         while (pushed < 150) begin
            len = $urandom_range(40, 1);
            queue_frame(len);
            pushed += len;
         end
         settle();
      end

      repeat (10) @(posedge clock);
      if (error_count == 0)
         $display("dial_region_color_hit_detector regression: pass");
      else
         $display("dial_region_color_hit_detector regression: fail");
      $finish;
   end

endmodule

/* dial_region_color_hit_detector.f */
src/drchd_pkg.sv
src/drchd_front.sv
src/drchd_queue.sv
src/drchd_back.sv
src/dial_region_color_hit_detector.sv
tb/dial_region_color_hit_detector_tb.sv
